### design/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define EFS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// The expression must never be true at a clock edge outside reset.
`define EFS_NEVER(lbl, expr, msg) \
	`EFS_ASSERT(lbl, !(expr), msg)

`endif

### design/efs_pkg.sv
// Shared types and constants for the earliest-free server scheduler.
// No dependencies; imported by the rate memory, the top level and the testbench.
`timescale 1ns / 1ps

package efs_pkg;

	localparam int CMD_W      = 2;
	localparam int SEL_W      = 4;
	localparam int RATE_W     = 10;
	localparam int ITEMS_W    = 10;
	localparam int PROD_W     = RATE_W + ITEMS_W;
	localparam int CNT_REG_W  = 5;
	localparam int OUT_ID_W   = 4;
	localparam int OUT_TIME_W = 32;

	typedef logic [CMD_W-1:0]   cmd_t;
	typedef logic [RATE_W-1:0]  rate_t;
	typedef logic [ITEMS_W-1:0] items_t;

	localparam cmd_t CMD_CLEAR  = 2'd0;
	localparam cmd_t CMD_LOAD   = 2'd1;
	localparam cmd_t CMD_ASSIGN = 2'd2;

endpackage

### design/efs_rate_mem.sv
// Per-server rate store: one write port, one registered read port.
// Entries never written since reset read as zero. Uses efs_pkg.
`timescale 1ns / 1ps

module efs_rate_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  efs_pkg::rate_t    wr_data,
	input  logic [AW-1:0]     rd_addr,
	output efs_pkg::rate_t    rd_data
);
	import efs_pkg::*;

	rate_t            mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	rate_t            rd_data_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
		rd_vld_q  <= vld_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

### design/efs_heap_mem.sv
// Heap slot store: free time and server id per slot, two registered read
// ports and one write port. No package dependency.
`timescale 1ns / 1ps

module efs_heap_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int TW    = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clr,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [TW-1:0] wr_time,
	input  logic [AW-1:0] wr_id,
	input  logic [AW-1:0] rd_addr_a,
	input  logic [AW-1:0] rd_addr_b,
	output logic [TW-1:0] rd_time_a,
	output logic [AW-1:0] rd_id_a,
	output logic [TW-1:0] rd_time_b,
	output logic [AW-1:0] rd_id_b
);
	logic [TW-1:0]    time_mem [DEPTH];
	logic [AW-1:0]    id_mem   [DEPTH];
	logic [DEPTH-1:0] vld_q;

	logic [TW-1:0] rd_time_a_q, rd_time_b_q;
	logic [AW-1:0] rd_id_a_q, rd_id_b_q;
	logic [AW-1:0] rd_addr_a_q, rd_addr_b_q;
	logic          rd_vld_a_q, rd_vld_b_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			time_mem[wr_addr] <= wr_time;
			id_mem[wr_addr]   <= wr_id;
		end
		rd_time_a_q <= time_mem[rd_addr_a];
		rd_id_a_q   <= id_mem[rd_addr_a];
		rd_vld_a_q  <= vld_q[rd_addr_a];
		rd_addr_a_q <= rd_addr_a;
		rd_time_b_q <= time_mem[rd_addr_b];
		rd_id_b_q   <= id_mem[rd_addr_b];
		rd_vld_b_q  <= vld_q[rd_addr_b];
		rd_addr_b_q <= rd_addr_b;
	end

	// A slot not written since the last clear holds its own server at time zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (clr) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	assign rd_time_a = rd_vld_a_q ? rd_time_a_q : '0;
	assign rd_id_a   = rd_vld_a_q ? rd_id_a_q   : rd_addr_a_q;
	assign rd_time_b = rd_vld_b_q ? rd_time_b_q : '0;
	assign rd_id_b   = rd_vld_b_q ? rd_id_b_q   : rd_addr_b_q;

endmodule

### design/earliest_free_server_scheduler.sv
// Earliest-free server scheduler: top level with command sequencer and sift-down.
// Depends on efs_pkg, efs_heap_mem, efs_rate_mem and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel   | Handshake                    | Beat contents
// ----------+------------------------------+-------------------------------------------
// command   | start, busy                  | cmd, server_sel, rate_value, item_count
// result    | done (one-cycle strobe)      | chosen_server, start_time, finish_time,
//           |                              | makespan
// config    | server_count_we              | server_count_wdata
//
// Clear and load beats complete at the edge that accepts them; busy stays low.
// An assign beat keeps busy high until the sift-down has finished, so the block
// takes no new command beat before then. The sift-down visits at most
// ceil(log2(MAX_SERVERS + 1)) heap levels; at each level it reads both children
// from the heap memory, then compares them with the moving entry and writes.
// The result beat is strobed on done while the sift-down is still running.
// Reset is asynchronous and active low; it leaves every server idle at time zero,
// all rates zero and the heap built over min(16, MAX_SERVERS) servers.
// The receiver cannot stall: a result beat is present for exactly one cycle.

module earliest_free_server_scheduler #(
	parameter int MAX_SERVERS = 16,
	parameter int TIME_WIDTH  = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  efs_pkg::cmd_t                       cmd,
	input  logic [efs_pkg::SEL_W-1:0]           server_sel,
	input  efs_pkg::rate_t                      rate_value,
	input  efs_pkg::items_t                     item_count,
	input  logic                                server_count_we,
	input  logic [efs_pkg::CNT_REG_W-1:0]       server_count_wdata,
	output logic                                done,
	output logic [efs_pkg::OUT_ID_W-1:0]        chosen_server,
	output logic [efs_pkg::OUT_TIME_W-1:0]      start_time,
	output logic [efs_pkg::OUT_TIME_W-1:0]      finish_time,
	output logic [efs_pkg::OUT_TIME_W-1:0]      makespan
);
	import efs_pkg::*;

	localparam int ID_W   = $clog2(MAX_SERVERS);
	localparam int CNT_W  = $clog2(MAX_SERVERS + 1);
	localparam int CH_W   = ID_W + 2;
	localparam int SUM_W  = ((TIME_WIDTH > PROD_W) ? TIME_WIDTH : PROD_W) + 1;
	localparam int LIVE_RST = (MAX_SERVERS < 16) ? MAX_SERVERS : 16;
	localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

	// Sequencer states.
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ROOT = 3'd1;
	localparam logic [2:0] S_RATE = 3'd2;
	localparam logic [2:0] S_ADD  = 3'd3;
	localparam logic [2:0] S_RD   = 3'd4;
	localparam logic [2:0] S_CMP  = 3'd5;

	// Heap ordering: earlier free time first, lower server id on a tie.
	function automatic logic precedes(
		input logic [TIME_WIDTH-1:0] at,
		input logic [ID_W-1:0]       ai,
		input logic [TIME_WIDTH-1:0] bt,
		input logic [ID_W-1:0]       bi
	);
		return (at < bt) || ((at == bt) && (ai < bi));
	endfunction

	logic [2:0]            state_q;
	logic [ID_W-1:0]       pos_q;
	logic [TIME_WIDTH-1:0] mov_time_q;
	logic [ID_W-1:0]       mov_id_q;
	items_t                items_q;
	logic [PROD_W-1:0]     prod_q;
	logic [CNT_W-1:0]      live_q;
	logic [TIME_WIDTH-1:0] makespan_q;
	logic [CNT_REG_W-1:0]  server_count_q;
	logic                  done_q;
	logic [OUT_ID_W-1:0]   chosen_q;
	logic [OUT_TIME_W-1:0] start_q;
	logic [OUT_TIME_W-1:0] finish_q;
	logic [OUT_TIME_W-1:0] makespan_out_q;

	logic accept;
	logic do_clear;
	logic do_load;

	// Heap memory ports.
	logic [ID_W-1:0]       hp_rd_addr_a, hp_rd_addr_b;
	logic [TIME_WIDTH-1:0] hp_time_a, hp_time_b;
	logic [ID_W-1:0]       hp_id_a, hp_id_b;
	logic                  hp_wr_en;
	logic [ID_W-1:0]       hp_wr_addr;
	logic [TIME_WIDTH-1:0] hp_wr_time;
	logic [ID_W-1:0]       hp_wr_id;

	// Rate memory ports.
	logic [ID_W+SEL_W-1:0] sel_ext;
	logic                  sel_in_range;
	rate_t                 rate_rd;

	// Sift-down datapath.
	logic [CH_W-1:0]       child_l, child_r, live_ext;
	logic                  l_in, r_in;
	logic                  l_before_m, r_before_m, r_before_l;
	logic                  take_l, take_r;

	// Saturating finish-time add.
	logic [SUM_W-1:0]      sum;
	logic [TIME_WIDTH-1:0] finish;
	logic [TIME_WIDTH-1:0] new_makespan;

	// Output narrowing to the fixed port widths.
	logic [ID_W+OUT_ID_W-1:0]         id_ext;
	logic [TIME_WIDTH+OUT_TIME_W-1:0] start_ext, finish_ext, makespan_ext;

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign do_clear = accept && (cmd == CMD_CLEAR);

	assign sel_ext      = (ID_W + SEL_W)'(server_sel);
	assign sel_in_range = (int'(server_sel) < MAX_SERVERS);
	assign do_load      = accept && (cmd == CMD_LOAD) && sel_in_range;

	// Children of the current position, wide enough never to wrap.
	assign child_l  = {1'b0, pos_q, 1'b1};
	assign child_r  = child_l + CH_W'(1);
	assign live_ext = CH_W'(live_q);
	assign l_in     = (child_l < live_ext);
	assign r_in     = (child_r < live_ext);

	// While idle, port A keeps the root slot fresh so an assign can start at once.
	assign hp_rd_addr_a = (state_q == S_IDLE) ? '0 : child_l[ID_W-1:0];
	assign hp_rd_addr_b = child_r[ID_W-1:0];

	// The three comparisons run side by side; the selection picks the smallest of
	// the moving entry and the in-range children.
	assign l_before_m = l_in && precedes(hp_time_a, hp_id_a, mov_time_q, mov_id_q);
	assign r_before_m = r_in && precedes(hp_time_b, hp_id_b, mov_time_q, mov_id_q);
	assign r_before_l = r_in && precedes(hp_time_b, hp_id_b, hp_time_a, hp_id_a);
	assign take_r     = l_before_m ? r_before_l : r_before_m;
	assign take_l     = l_before_m && !r_before_l;

	always_comb begin
		hp_wr_en   = (state_q == S_CMP);
		hp_wr_addr = pos_q;
		hp_wr_time = mov_time_q;
		hp_wr_id   = mov_id_q;
		if (take_r) begin
			hp_wr_time = hp_time_b;
			hp_wr_id   = hp_id_b;
		end else if (take_l) begin
			hp_wr_time = hp_time_a;
			hp_wr_id   = hp_id_a;
		end
	end

	assign sum          = SUM_W'(mov_time_q) + SUM_W'(prod_q);
	assign finish       = (sum > SUM_W'(TIME_MAX)) ? TIME_MAX : sum[TIME_WIDTH-1:0];
	assign new_makespan = (finish > makespan_q) ? finish : makespan_q;

	assign id_ext       = (ID_W + OUT_ID_W)'(mov_id_q);
	assign start_ext    = (TIME_WIDTH + OUT_TIME_W)'(mov_time_q);
	assign finish_ext   = (TIME_WIDTH + OUT_TIME_W)'(finish);
	assign makespan_ext = (TIME_WIDTH + OUT_TIME_W)'(new_makespan);

	efs_heap_mem #(
		.DEPTH (MAX_SERVERS),
		.AW    (ID_W),
		.TW    (TIME_WIDTH)
	) u_heap (
		.clk       (clk),
		.arst_n    (arst_n),
		.clr       (do_clear),
		.wr_en     (hp_wr_en),
		.wr_addr   (hp_wr_addr),
		.wr_time   (hp_wr_time),
		.wr_id     (hp_wr_id),
		.rd_addr_a (hp_rd_addr_a),
		.rd_addr_b (hp_rd_addr_b),
		.rd_time_a (hp_time_a),
		.rd_id_a   (hp_id_a),
		.rd_time_b (hp_time_b),
		.rd_id_b   (hp_id_b)
	);

	// The rate lookup is addressed straight from the registered root read.
	efs_rate_mem #(
		.DEPTH (MAX_SERVERS),
		.AW    (ID_W)
	) u_rate (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (do_load),
		.wr_addr (sel_ext[ID_W-1:0]),
		.wr_data (rate_value),
		.rd_addr (hp_id_a),
		.rd_data (rate_rd)
	);

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			pos_q          <= '0;
			live_q         <= CNT_W'(LIVE_RST);
			makespan_q     <= '0;
			server_count_q <= CNT_REG_W'(16);
			done_q         <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (server_count_we) begin
				server_count_q <= server_count_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					pos_q <= '0;
					if (do_clear) begin
						makespan_q <= '0;
						if (server_count_q == '0) begin
							live_q <= CNT_W'(1);
						end else if (int'(server_count_q) > MAX_SERVERS) begin
							live_q <= CNT_W'(MAX_SERVERS);
						end else begin
							live_q <= CNT_W'(server_count_q);
						end
					end
					if (accept && (cmd == CMD_ASSIGN)) begin
						state_q <= S_ROOT;
					end
				end
				S_ROOT: state_q <= S_RATE;
				S_RATE: state_q <= S_ADD;
				S_ADD: begin
					makespan_q <= new_makespan;
					done_q     <= 1'b1;
					state_q    <= S_CMP;
				end
				S_RD: state_q <= S_CMP;
				S_CMP: begin
					if (take_r) begin
						pos_q   <= child_r[ID_W-1:0];
						state_q <= S_RD;
					end else if (take_l) begin
						pos_q   <= child_l[ID_W-1:0];
						state_q <= S_RD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers: the moving entry, the job size and the result beat.
	always_ff @(posedge clk) begin
		if (accept) begin
			items_q <= item_count;
		end
		if (state_q == S_ROOT) begin
			mov_time_q <= hp_time_a;
			mov_id_q   <= hp_id_a;
		end
		if (state_q == S_RATE) begin
			prod_q <= PROD_W'(rate_rd) * PROD_W'(items_q);
		end
		if (state_q == S_ADD) begin
			mov_time_q     <= finish;
			chosen_q       <= id_ext[OUT_ID_W-1:0];
			start_q        <= start_ext[OUT_TIME_W-1:0];
			finish_q       <= finish_ext[OUT_TIME_W-1:0];
			makespan_out_q <= makespan_ext[OUT_TIME_W-1:0];
		end
	end

	assign done          = done_q;
	assign chosen_server = chosen_q;
	assign start_time    = start_q;
	assign finish_time   = finish_q;
	assign makespan      = makespan_out_q;

	// A result beat lasts one cycle and is never followed directly by another.
	`EFS_ASSERT(a_done_single, done_q |=> !done_q, "result strobe held for two cycles")
	// The makespan covers the finish time just reported.
	`EFS_ASSERT(a_makespan_cover, done_q |-> (makespan_q >= mov_time_q),
		"makespan below the finish time of the last job")
	// The result is strobed while the sift-down is still running.
	`EFS_NEVER(a_done_idle, done_q && !busy, "result strobed with the sequencer idle")
	// The sift-down never moves outside the live part of the heap.
	`EFS_ASSERT(a_pos_live, (state_q == S_CMP) |-> (CNT_W'(pos_q) < live_q),
		"sift position beyond the live heap")

endmodule

### sim/tb_earliest_free_server_scheduler.sv
// Self-checking testbench for the earliest-free server scheduler.
// Depends on efs_pkg and earliest_free_server_scheduler; predicts every assignment itself.
`timescale 1ns / 1ps

module tb_earliest_free_server_scheduler;
	import efs_pkg::*;

	// The block is built with its default of sixteen servers and 32-bit times.
	localparam int   SERVERS       = 16;
	localparam int   SETTLE_CYCLES = 12;
	localparam int   QUIET_BOUND   = 100_000;
	// Command code 3 has no meaning; the block must swallow it without a result.
	localparam cmd_t CMD_UNUSED    = 2'd3;

	typedef logic [SEL_W-1:0]        sel_t;
	typedef logic [OUT_TIME_W-1:0]   stamp_t;
	typedef logic [OUT_TIME_W:0]     wide_stamp_t;
	typedef logic [CNT_REG_W-1:0]    count_t;

	localparam stamp_t TIME_CEILING = '1;

	typedef struct packed {
		cmd_t   cmd;
		sel_t   sel;
		rate_t  rate;
		items_t items;
	} job_beat_t;

	typedef struct packed {
		sel_t   server;
		stamp_t t_start;
		stamp_t t_finish;
		stamp_t span;
	} assignment_t;

	// Every input starts at a known value; the driver and the register writer take over later.
	logic   clk                = 1'b0;
	logic   arst_n             = 1'b0;
	logic   start              = 1'b0;
	cmd_t   cmd                = CMD_CLEAR;
	sel_t   server_sel         = '0;
	rate_t  rate_value         = '0;
	items_t item_count         = '0;
	logic   server_count_we    = 1'b0;
	count_t server_count_wdata = '0;
	logic   busy;
	logic   done;
	sel_t   chosen_server;
	stamp_t start_time;
	stamp_t finish_time;
	stamp_t makespan;

	earliest_free_server_scheduler u_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (start),
		.busy               (busy),
		.cmd                (cmd),
		.server_sel         (server_sel),
		.rate_value         (rate_value),
		.item_count         (item_count),
		.server_count_we    (server_count_we),
		.server_count_wdata (server_count_wdata),
		.done               (done),
		.chosen_server      (chosen_server),
		.start_time         (start_time),
		.finish_time        (finish_time),
		.makespan           (makespan)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor state: our own copy of the heap, the rate table and the
	// server count register.
	// ------------------------------------------------------------------
	stamp_t free_at[SERVERS];
	sel_t   slot_server[SERVERS];
	rate_t  rate_of[SERVERS];
	stamp_t span_so_far;
	int     live_slots;
	count_t count_reg;

	job_beat_t   command_queue[$];
	assignment_t pending_assignments[$];

	int mismatches        = 0;
	int results_checked   = 0;
	int saturated_results = 0;
	int clears_sent       = 0;
	int loads_sent        = 0;
	int ignored_sent      = 0;
	int settings_seen     = 0;

	// Heap order is total: earlier free time first, then the lower server id.
	function automatic bit slot_precedes(int a, int b);
		if (free_at[a] != free_at[b])
			return free_at[a] < free_at[b];
		return slot_server[a] < slot_server[b];
	endfunction

	// Push the root entry down until neither child comes before it.
	function automatic void sift_from_root();
		int     pos;
		int     best;
		int     lhs;
		int     rhs;
		stamp_t t_swap;
		sel_t   s_swap;
		pos = 0;
		while (1) begin
			best = pos;
			lhs  = 2 * pos + 1;
			rhs  = lhs + 1;
			if (lhs < live_slots && slot_precedes(lhs, best))
				best = lhs;
			if (rhs < live_slots && slot_precedes(rhs, best))
				best = rhs;
			if (best == pos)
				break;
			t_swap            = free_at[pos];
			s_swap            = slot_server[pos];
			free_at[pos]      = free_at[best];
			slot_server[pos]  = slot_server[best];
			free_at[best]     = t_swap;
			slot_server[best] = s_swap;
			pos               = best;
		end
	endfunction

	// A clear takes the register as it stands now; zero counts as one server and anything
	// above sixteen as sixteen.
	function automatic void rebuild_heap();
		int n;
		n = count_reg;
		if (n < 1)
			n = 1;
		if (n > SERVERS)
			n = SERVERS;
		live_slots = n;
		for (int i = 0; i < SERVERS; i++) begin
			free_at[i]     = '0;
			slot_server[i] = sel_t'(i);
		end
		span_so_far = '0;
	endfunction

	// Applies one accepted command beat to the predictor and, for an assignment, records
	// the result that the block owes us.
	function automatic void schedule_job(job_beat_t b);
		sel_t        id;
		stamp_t      t0;
		stamp_t      t1;
		wide_stamp_t sum;
		case (b.cmd)
			CMD_CLEAR: begin
				rebuild_heap();
				clears_sent++;
			end
			CMD_LOAD: begin
				rate_of[b.sel] = b.rate;
				loads_sent++;
			end
			CMD_ASSIGN: begin
				id  = slot_server[0];
				t0  = free_at[0];
				sum = wide_stamp_t'(t0) + wide_stamp_t'(rate_of[id]) * wide_stamp_t'(b.items);
				// A carry out of the time width means the finish time saturates.
				t1  = sum[OUT_TIME_W] ? TIME_CEILING : sum[OUT_TIME_W-1:0];
				free_at[0] = t1;
				sift_from_root();
				if (t1 > span_so_far)
					span_so_far = t1;
				pending_assignments.push_back('{id, t0, t1, span_so_far});
			end
			default: begin
				ignored_sent++;
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Command driver. A beat is accepted at an edge where start is high and
	// busy is low. The gap after each accepted beat is mostly short, now and
	// then long, and occasionally a burst of back-to-back beats follows.
	// Now and then the driver also holds off until the block has gone
	// completely quiet.
	// ------------------------------------------------------------------
	int gap_left   = 0;
	int burst_left = 0;
	bit drain_hold = 1'b0;
	bit settled    = 1'b0;

	function automatic int next_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			burst_left = $urandom_range(30, 120);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk) begin : driver
		job_beat_t nxt;
		logic      start_nxt;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			start_nxt = start;
			if (start && !busy) begin
				schedule_job('{cmd, server_sel, rate_value, item_count});
				start_nxt = 1'b0;
			end
			// start is given exactly one nonblocking update per edge, so a beat that
			// follows straight on keeps start high without a glitch.
			if (!start_nxt) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (drain_hold) begin
					if (settled)
						drain_hold = 1'b0;
				end else if (command_queue.size() > 0) begin
					nxt        = command_queue.pop_front();
					cmd        <= nxt.cmd;
					server_sel <= nxt.sel;
					rate_value <= nxt.rate;
					item_count <= nxt.items;
					start_nxt  = 1'b1;
					gap_left   = next_gap();
					if ($urandom_range(0, 149) == 0)
						drain_hold = 1'b1;
				end
			end
			start <= start_nxt;
		end
	end

	// Quiet means no beat offered, nothing owed and the sift-down finished. It is
	// worked out at the falling edge so that nothing depends on the order of
	// processes at the rising edge.
	always @(negedge clk) begin
		settled = !start && (pending_assignments.size() == 0) && !busy;
	end

	// ------------------------------------------------------------------
	// Result monitor. The receiver cannot stall, so every cycle with done
	// high is one result beat, taken at the edge that closes that cycle.
	// ------------------------------------------------------------------
	function automatic void check_field(string name, stamp_t want, stamp_t got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : monitor
		assignment_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_assignments.size() == 0) begin
				$error("result beat with no assignment outstanding (server %0d)", chosen_server);
				mismatches++;
			end else begin
				want = pending_assignments.pop_front();
				check_field("chosen_server", stamp_t'(want.server), stamp_t'(chosen_server));
				check_field("start_time", want.t_start, start_time);
				check_field("finish_time", want.t_finish, finish_time);
				check_field("makespan", want.span, makespan);
				results_checked++;
				if (want.t_finish == TIME_CEILING)
					saturated_results++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------
	function automatic void add_job(cmd_t c, sel_t s, rate_t r, items_t n);
		command_queue.push_back('{c, s, r, n});
	endfunction

	// Ten-bit values lean towards the corners: zero, all ones and single bits.
	function automatic logic [9:0] pick_ten();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2:       return 10'd1 << $urandom_range(0, 9);
			default: return 10'($urandom);
		endcase
	endfunction

	function automatic void load_all_rates();
		for (int i = 0; i < SERVERS; i++)
			add_job(CMD_LOAD, sel_t'(i), pick_ten(), items_t'($urandom));
	endfunction

	// Fields that a command does not use still carry random values.
	function automatic void add_random_job();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			add_job(CMD_ASSIGN, sel_t'($urandom), rate_t'($urandom), pick_ten());
		end else if (r < 84) begin
			add_job(CMD_LOAD, sel_t'($urandom), pick_ten(), items_t'($urandom));
		end else if (r < 88) begin
			add_job(CMD_CLEAR, sel_t'($urandom), rate_t'($urandom), items_t'($urandom));
			load_all_rates();
		end else if (r < 92) begin
			add_job(CMD_CLEAR, sel_t'($urandom), rate_t'($urandom), items_t'($urandom));
		end else begin
			add_job(CMD_UNUSED, sel_t'($urandom), rate_t'($urandom), items_t'($urandom));
		end
	endfunction

	// Waits until every queued beat is accepted, every result has come and the
	// sift-down is over, then gives the block a few more cycles. A block that
	// never goes quiet is reported rather than waited on for ever.
	task automatic wait_quiet();
		int guard;
		guard = 0;
		do begin
			@(negedge clk);
			guard++;
		end while (!(command_queue.size() == 0 && !start && !drain_hold
			&& pending_assignments.size() == 0 && !busy) && guard < QUIET_BOUND);
		if (guard >= QUIET_BOUND) begin
			$error("block did not go quiet: %0d results still outstanding",
				pending_assignments.size());
			mismatches++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Register writes happen only while the block is idle. The new count only
	// takes effect at the next clear.
	task automatic count_write(count_t value);
		@(posedge clk);
		server_count_we    <= 1'b1;
		server_count_wdata <= value;
		@(posedge clk);
		server_count_we    <= 1'b0;
		server_count_wdata <= count_t'($urandom);
		count_reg = value;
		settings_seen++;
	endtask

	task automatic run_phase(count_t setting, int n, bit open_with_clear);
		wait_quiet();
		count_write(setting);
		@(negedge clk);
		if (open_with_clear) begin
			add_job(CMD_CLEAR, sel_t'($urandom), rate_t'($urandom), items_t'($urandom));
			load_all_rates();
		end
		repeat (n) add_random_job();
	endtask

	// ------------------------------------------------------------------
	// Test sequence.
	// ------------------------------------------------------------------
	initial begin : stimulus
		count_t extra;
		// Predictor reset: sixteen servers, all idle at time zero, all rates zero.
		count_reg = count_t'(SERVERS);
		for (int i = 0; i < SERVERS; i++)
			rate_of[i] = '0;
		rebuild_heap();

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed opening with the count left at its reset value. With every rate at
		// zero the first job costs nothing, so server 0 keeps the root by its lower id.
		add_job(CMD_ASSIGN, sel_t'($urandom), rate_t'($urandom), '1);
		add_job(CMD_LOAD, '0, '1, items_t'($urandom));
		add_job(CMD_LOAD, '1, '1, items_t'($urandom));
		add_job(CMD_LOAD, 4'd1, 10'd1, items_t'($urandom));
		add_job(CMD_LOAD, 4'd2, 10'h155, items_t'($urandom));
		add_job(CMD_LOAD, 4'd3, 10'h2AA, items_t'($urandom));
		add_job(CMD_UNUSED, sel_t'($urandom), rate_t'($urandom), items_t'($urandom));
		add_job(CMD_ASSIGN, sel_t'($urandom), rate_t'($urandom), '1);
		add_job(CMD_ASSIGN, sel_t'($urandom), rate_t'($urandom), '0);
		add_job(CMD_ASSIGN, sel_t'($urandom), rate_t'($urandom), 10'd1);
		add_job(CMD_ASSIGN, sel_t'($urandom), rate_t'($urandom), 10'h155);
		add_job(CMD_ASSIGN, sel_t'($urandom), rate_t'($urandom), 10'h2AA);
		// Servers with rate zero finish at once and so hold the root between them.
		repeat (3) add_job(CMD_ASSIGN, sel_t'($urandom), rate_t'($urandom), '1);
		add_job(CMD_CLEAR, sel_t'($urandom), rate_t'($urandom), items_t'($urandom));
		add_job(CMD_LOAD, 4'd4, 10'd7, items_t'($urandom));
		repeat (6) add_job(CMD_ASSIGN, sel_t'($urandom), rate_t'($urandom), 10'd200);

		// One live server (a written zero counts as one) at the largest rate: the
		// largest jobs push its free time up by the most that a single job can add.
		wait_quiet();
		count_write('0);
		@(negedge clk);
		add_job(CMD_CLEAR, sel_t'($urandom), rate_t'($urandom), items_t'($urandom));
		add_job(CMD_LOAD, '0, '1, items_t'($urandom));
		repeat (24) add_job(CMD_ASSIGN, sel_t'($urandom), rate_t'($urandom), '1);
		add_job(CMD_ASSIGN, sel_t'($urandom), rate_t'($urandom), '0);
		add_job(CMD_ASSIGN, sel_t'($urandom), rate_t'($urandom), 10'd5);

		// Random phases over a spread of counts, the top of the register among them.
		// The phase at count 1 opens without a clear, so it still runs on the heap
		// built at the previous setting until a clear comes along.
		run_phase(count_t'(31), 128, 1'b1);
		run_phase(count_t'(1), 128, 1'b0);
		run_phase(count_t'(2), 128, 1'b1);
		run_phase(count_t'(16), 128, 1'b1);
		run_phase(count_t'(17), 128, 1'b1);
		run_phase(count_t'(7), 128, 1'b1);
		repeat (2) begin
			extra = count_t'($urandom_range(1, 31));
			run_phase(extra, 128, $urandom_range(0, 3) != 0);
		end

		wait_quiet();
		repeat (20) @(negedge clk);
		if (pending_assignments.size() != 0) begin
			$error("%0d expected results never arrived", pending_assignments.size());
			mismatches++;
		end

		$display("Checked %0d assignment results over %0d register settings and the reset value.",
			results_checked, settings_seen);
		$display("Sent %0d clears, %0d rate loads, %0d unused commands; %0d results saturated.",
			clears_sent, loads_sent, ignored_sent, saturated_results);
		if (mismatches == 0) begin
			$display("** earliest_free_server_scheduler: PASSED **");
		end else begin
			$display("** earliest_free_server_scheduler: FAILED **");
		end
		$finish;
	end

	// Overall limit, far beyond the slowest correct run.
	initial begin : watchdog
		#20_000_000;
		$display("Run timed out with %0d results outstanding.", pending_assignments.size());
		$display("** earliest_free_server_scheduler: FAILED **");
		$finish;
	end

endmodule
